// File: hw/rtl/cpu6502_load_jump_subset_core_macros.svh
// ----------------------------------------------------------------------------
// cpu6502_load_jump_subset_core_macros
// assertion macros shared by the core; empty bodies when synthesizing
// ----------------------------------------------------------------------------
`ifndef CPU6502_LOAD_JUMP_SUBSET_CORE_MACROS_SVH
`define CPU6502_LOAD_JUMP_SUBSET_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define C6502LJS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// antecedent implies consequent on the next clock edge
`define C6502LJS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define C6502LJS_ASSERT(label, prop, msg)
`define C6502LJS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: hw/rtl/c6502ljs_pkg.sv
// ----------------------------------------------------------------------------
// c6502ljs_pkg
// types, constants and opcode decode for the load and jump subset core
// ----------------------------------------------------------------------------
package c6502ljs_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int ADDR_W    = 16;

	// reset values
	localparam logic [15:0] RESET_PC   = 16'hFFFC;
	localparam logic [7:0]  RESET_SP   = 8'hFF;
	localparam logic [7:0]  INIT_BYTE0 = 8'hFF;
	localparam logic [7:0]  INIT_BYTE1 = 8'h07;
	localparam logic [7:0]  STACK_PAGE = 8'h01;

	// action codes
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_EXEC  = 2'd2;

	// addressing modes
	localparam logic [2:0] MD_IMM  = 3'd0;
	localparam logic [2:0] MD_ZP   = 3'd1;
	localparam logic [2:0] MD_ABS  = 3'd2;
	localparam logic [2:0] MD_INDX = 3'd3;
	localparam logic [2:0] MD_INDY = 3'd4;
	localparam logic [2:0] MD_JMP  = 3'd5;
	localparam logic [2:0] MD_JSR  = 3'd6;

	// load destinations
	localparam logic [1:0] DST_A = 2'd0;
	localparam logic [1:0] DST_X = 2'd1;
	localparam logic [1:0] DST_Y = 2'd2;

	// index register selects
	localparam logic [1:0] IDX_NONE = 2'd0;
	localparam logic [1:0] IDX_X    = 2'd1;
	localparam logic [1:0] IDX_Y    = 2'd2;

	// opcodes
	localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
	localparam logic [7:0] OP_LDX_IMM  = 8'hA2;
	localparam logic [7:0] OP_LDY_IMM  = 8'hA0;
	localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
	localparam logic [7:0] OP_LDX_ZP   = 8'hA6;
	localparam logic [7:0] OP_LDY_ZP   = 8'hA4;
	localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
	localparam logic [7:0] OP_LDX_ZPY  = 8'hB6;
	localparam logic [7:0] OP_LDY_ZPX  = 8'hB4;
	localparam logic [7:0] OP_LDA_ABS  = 8'hAD;
	localparam logic [7:0] OP_LDX_ABS  = 8'hAE;
	localparam logic [7:0] OP_LDY_ABS  = 8'hAC;
	localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
	localparam logic [7:0] OP_LDA_ABSY = 8'hB9;
	localparam logic [7:0] OP_LDX_ABSY = 8'hBE;
	localparam logic [7:0] OP_LDY_ABSX = 8'hBC;
	localparam logic [7:0] OP_LDA_INDX = 8'hA1;
	localparam logic [7:0] OP_LDA_INDY = 8'hB1;
	localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
	localparam logic [7:0] OP_JSR      = 8'h20;

	// decoded opcode
	typedef struct packed {
		logic       ok;
		logic [2:0] mode;
		logic [1:0] dst;
		logic [1:0] idx;
		logic [2:0] cyc;
	} dec_t;

	// memory port request
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic dec_t decode_op(input logic [7:0] op);
		dec_t d;
		d = '{ok: 1'b1, mode: MD_IMM, dst: DST_A, idx: IDX_NONE, cyc: 3'd2};
		case (op)
			OP_LDA_IMM:  d = '{1'b1, MD_IMM,  DST_A, IDX_NONE, 3'd2};
			OP_LDX_IMM:  d = '{1'b1, MD_IMM,  DST_X, IDX_NONE, 3'd2};
			OP_LDY_IMM:  d = '{1'b1, MD_IMM,  DST_Y, IDX_NONE, 3'd2};
			OP_LDA_ZP:   d = '{1'b1, MD_ZP,   DST_A, IDX_NONE, 3'd3};
			OP_LDX_ZP:   d = '{1'b1, MD_ZP,   DST_X, IDX_NONE, 3'd3};
			OP_LDY_ZP:   d = '{1'b1, MD_ZP,   DST_Y, IDX_NONE, 3'd3};
			OP_LDA_ZPX:  d = '{1'b1, MD_ZP,   DST_A, IDX_X,    3'd4};
			OP_LDX_ZPY:  d = '{1'b1, MD_ZP,   DST_X, IDX_Y,    3'd4};
			OP_LDY_ZPX:  d = '{1'b1, MD_ZP,   DST_Y, IDX_X,    3'd4};
			OP_LDA_ABS:  d = '{1'b1, MD_ABS,  DST_A, IDX_NONE, 3'd4};
			OP_LDX_ABS:  d = '{1'b1, MD_ABS,  DST_X, IDX_NONE, 3'd4};
			OP_LDY_ABS:  d = '{1'b1, MD_ABS,  DST_Y, IDX_NONE, 3'd4};
			OP_LDA_ABSX: d = '{1'b1, MD_ABS,  DST_A, IDX_X,    3'd4};
			OP_LDA_ABSY: d = '{1'b1, MD_ABS,  DST_A, IDX_Y,    3'd4};
			OP_LDX_ABSY: d = '{1'b1, MD_ABS,  DST_X, IDX_Y,    3'd4};
			OP_LDY_ABSX: d = '{1'b1, MD_ABS,  DST_Y, IDX_X,    3'd4};
			OP_LDA_INDX: d = '{1'b1, MD_INDX, DST_A, IDX_X,    3'd6};
			OP_LDA_INDY: d = '{1'b1, MD_INDY, DST_A, IDX_Y,    3'd5};
			OP_JMP_ABS:  d = '{1'b1, MD_JMP,  DST_A, IDX_NONE, 3'd3};
			OP_JSR:      d = '{1'b1, MD_JSR,  DST_A, IDX_NONE, 3'd6};
			default:     d = '{1'b0, MD_IMM,  DST_A, IDX_NONE, 3'd1};
		endcase
		return d;
	endfunction

endpackage

// File: hw/rtl/c6502ljs_mem.sv
// ----------------------------------------------------------------------------
// c6502ljs_mem
// 64 KiB byte memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module c6502ljs_mem
	import c6502ljs_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output logic [7:0] rdata
);

	logic [7:0] mem_q [MEM_BYTES];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/cpu6502_load_jump_subset_core.sv
// ----------------------------------------------------------------------------
// cpu6502_load_jump_subset_core
// load and jump subset of an 8-bit cpu with a private 64 KiB memory
// ----------------------------------------------------------------------------
// resources: one memory access per cycle through the single read port
// and one 16-bit adder
// throughput: one item at a time; the next item is taken once the result is
// registered, while that result may still wait on the output side
// reset: asynchronous, then a clearing pass over all 65536 bytes initializes
// the memory before the first item is taken
// ----------------------------------------------------------------------------
`include "cpu6502_load_jump_subset_core_macros.svh"

module cpu6502_load_jump_subset_core
	import c6502ljs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[0], read_data[8:1], cycles[11:9], prog_counter[27:12],
	// stack_ptr[35:28], acc[43:36], index_x[51:44], index_y[59:52],
	// flag_neg[60], flag_zero[61], zero fill[63:62]
	output logic [63:0] m_tdata
);

	// sequencer states
	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_RDWAIT = 4'd2;
	localparam logic [3:0] ST_OP     = 4'd3;
	localparam logic [3:0] ST_OPND1  = 4'd4;
	localparam logic [3:0] ST_OPND2  = 4'd5;
	localparam logic [3:0] ST_PUSH1  = 4'd6;
	localparam logic [3:0] ST_PUSH2  = 4'd7;
	localparam logic [3:0] ST_PTRLO  = 4'd8;
	localparam logic [3:0] ST_PTRHI  = 4'd9;
	localparam logic [3:0] ST_LOADV  = 4'd10;
	localparam logic [3:0] ST_DONE   = 4'd11;

	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_BYTES - 1);

	logic [3:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [15:0]       pc_q;
	logic [7:0]        sp_q;
	logic [7:0]        a_q;
	logic [7:0]        x_q;
	logic [7:0]        y_q;
	logic              n_q;
	logic              z_q;
	dec_t              dec_q;
	logic [7:0]        lo_q;
	logic [7:0]        ptr_q;
	logic [15:0]       ea_q;
	logic [7:0]        ret_lo_q;
	logic              cross_q;
	logic              status_q;
	logic [7:0]        rd_data_q;
	logic [2:0]        cyc_q;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;

	mem_req_t    mem_req;
	logic [7:0]  mem_rdata;
	dec_t        op_dec;
	logic [7:0]  idx_val;
	logic [15:0] base;
	logic [15:0] add_a;
	logic [15:0] add_b;
	logic [15:0] sum;
	logic        page_cross;
	logic        do_load;
	logic [2:0]  cyc_out;

	c6502ljs_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign op_dec = decode_op(mem_rdata);

	// index register picked by the decoded opcode
	always_comb begin
		case (dec_q.idx)
			IDX_X:   idx_val = x_q;
			IDX_Y:   idx_val = y_q;
			default: idx_val = 8'h00;
		endcase
	end

	assign base       = {mem_rdata, lo_q};
	assign sum        = add_a + add_b;
	assign page_cross = (base[15:8] != sum[15:8]);

	// shared adder operands and memory requests per step
	always_comb begin
		add_a         = pc_q;
		add_b         = 16'd1;
		mem_req       = '0;
		mem_req.raddr = pc_q;
		case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				if (clr_q == ADDR_W'(0)) begin
					mem_req.wdata = INIT_BYTE0;
				end else if (clr_q == ADDR_W'(1)) begin
					mem_req.wdata = INIT_BYTE1;
				end else begin
					mem_req.wdata = 8'h00;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						ACT_WRITE: begin
							mem_req.we    = 1'b1;
							mem_req.waddr = s_tdata[15:0];
							mem_req.wdata = s_tdata[23:16];
						end
						ACT_READ: begin
							mem_req.re    = 1'b1;
							mem_req.raddr = s_tdata[15:0];
						end
						ACT_EXEC: begin
							mem_req.re = 1'b1;
						end
						default: begin
							mem_req.re = 1'b0;
						end
					endcase
				end
			end
			ST_OP: begin
				mem_req.re = 1'b1;
			end
			ST_OPND1: begin
				case (dec_q.mode)
					MD_IMM: begin
						mem_req.re = 1'b0;
					end
					MD_ZP, MD_INDX, MD_INDY: begin
						add_a         = {8'h00, mem_rdata};
						add_b         = (dec_q.mode == MD_INDY) ? 16'd0 : {8'h00, idx_val};
						mem_req.re    = 1'b1;
						mem_req.raddr = {8'h00, sum[7:0]};
					end
					default: begin
						mem_req.re = 1'b1;
					end
				endcase
			end
			ST_OPND2: begin
				case (dec_q.mode)
					MD_ABS: begin
						add_a         = base;
						add_b         = {8'h00, idx_val};
						mem_req.re    = 1'b1;
						mem_req.raddr = sum;
					end
					MD_JSR: begin
						add_b         = 16'hFFFF;
						mem_req.we    = 1'b1;
						mem_req.waddr = {STACK_PAGE, sp_q};
						mem_req.wdata = sum[15:8];
					end
					default: begin
						mem_req.re = 1'b0;
					end
				endcase
			end
			ST_PUSH1: begin
				add_a         = {8'h00, sp_q};
				add_b         = 16'hFFFF;
				mem_req.we    = 1'b1;
				mem_req.waddr = {STACK_PAGE, sum[7:0]};
				mem_req.wdata = ret_lo_q;
			end
			ST_PUSH2: begin
				add_a = {8'h00, sp_q};
				add_b = 16'hFFFF;
			end
			ST_PTRLO: begin
				add_a         = {8'h00, ptr_q};
				mem_req.re    = 1'b1;
				mem_req.raddr = {8'h00, sum[7:0]};
			end
			ST_PTRHI: begin
				add_a         = base;
				add_b         = (dec_q.mode == MD_INDY) ? {8'h00, y_q} : 16'd0;
				mem_req.re    = 1'b1;
				mem_req.raddr = sum;
			end
			default: begin
				mem_req.re = 1'b0;
			end
		endcase
	end

	// loaded byte arrives on the read port in these steps
	assign do_load = (state_q == ST_LOADV) ||
	                 ((state_q == ST_OPND1) && (dec_q.mode == MD_IMM));

	assign cyc_out = cyc_q + {2'b00, cross_q};

	// sequencer and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			pc_q       <= RESET_PC;
			sp_q       <= RESET_SP;
			a_q        <= 8'h00;
			x_q        <= 8'h00;
			y_q        <= 8'h00;
			n_q        <= 1'b0;
			z_q        <= 1'b0;
			dec_q      <= '0;
			lo_q       <= 8'h00;
			ptr_q      <= 8'h00;
			ea_q       <= 16'h0000;
			ret_lo_q   <= 8'h00;
			cross_q    <= 1'b0;
			status_q   <= 1'b0;
			rd_data_q  <= 8'h00;
			cyc_q      <= 3'd0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// output side transfer, the done step reloads the register itself
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			// load destination and flags
			if (do_load) begin
				case (dec_q.dst)
					DST_X:   x_q <= mem_rdata;
					DST_Y:   y_q <= mem_rdata;
					default: a_q <= mem_rdata;
				endcase
				n_q <= mem_rdata[7];
				z_q <= (mem_rdata == 8'h00);
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						status_q  <= 1'b0;
						rd_data_q <= 8'h00;
						cyc_q     <= 3'd0;
						cross_q   <= 1'b0;
						case (s_tuser)
							ACT_READ: state_q <= ST_RDWAIT;
							ACT_EXEC: begin
								pc_q    <= sum;
								state_q <= ST_OP;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_RDWAIT: begin
					rd_data_q <= mem_rdata;
					state_q   <= ST_DONE;
				end
				ST_OP: begin
					dec_q    <= op_dec;
					cyc_q    <= op_dec.cyc;
					status_q <= !op_dec.ok;
					if (op_dec.ok) begin
						pc_q    <= sum;
						state_q <= ST_OPND1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_OPND1: begin
					lo_q <= mem_rdata;
					case (dec_q.mode)
						MD_IMM:  state_q <= ST_DONE;
						MD_ZP:   state_q <= ST_LOADV;
						MD_INDX, MD_INDY: begin
							ptr_q   <= sum[7:0];
							state_q <= ST_PTRLO;
						end
						default: begin
							pc_q    <= sum;
							state_q <= ST_OPND2;
						end
					endcase
				end
				ST_OPND2: begin
					case (dec_q.mode)
						MD_ABS: begin
							cross_q <= page_cross;
							state_q <= ST_LOADV;
						end
						MD_JSR: begin
							ret_lo_q <= sum[7:0];
							ea_q     <= base;
							state_q  <= ST_PUSH1;
						end
						default: begin
							pc_q    <= base;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_PUSH1: begin
					sp_q    <= sum[7:0];
					state_q <= ST_PUSH2;
				end
				ST_PUSH2: begin
					sp_q    <= sum[7:0];
					pc_q    <= ea_q;
					state_q <= ST_DONE;
				end
				ST_PTRLO: begin
					lo_q    <= mem_rdata;
					state_q <= ST_PTRHI;
				end
				ST_PTRHI: begin
					cross_q <= page_cross;
					state_q <= ST_LOADV;
				end
				ST_LOADV: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, z_q, n_q, y_q, x_q, a_q, sp_q, pc_q,
						               cyc_out, rd_data_q, status_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	`C6502LJS_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state_q != ST_IDLE, "accepted item did not start work")
	`C6502LJS_ASSERT(a_write_steps, !mem_req.we || state_q == ST_CLEAR || state_q == ST_IDLE || state_q == ST_OPND2 || state_q == ST_PUSH1, "memory write outside a write step")
	`C6502LJS_ASSERT(a_sp_only_jsr, (sp_q == $past(sp_q)) || $past(state_q) == ST_PUSH1 || $past(state_q) == ST_PUSH2, "stack pointer moved outside a subroutine call")
	`C6502LJS_ASSERT(a_result_from_done, !$rose(m_tvalid) || $past(state_q) == ST_DONE, "result shown without finishing an item")

endmodule
